>>> src/sync_frame_parser_xor_check_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync frame parser
// Clocked property checks, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef SYNC_FRAME_PARSER_XOR_CHECK_ASSERT_SVH
`define SYNC_FRAME_PARSER_XOR_CHECK_ASSERT_SVH

// checked only outside reset
`define SFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/sfp_pkg.sv
// ---------------------------------------------------------------------------
// Sync frame parser package
// Header bytes, field offsets, store depth, status codes and the result record type.
// ---------------------------------------------------------------------------
package sfp_pkg;

    localparam logic [7:0]  HDR_FIRST    = 8'hAA;
    localparam logic [7:0]  HDR_SECOND   = 8'h55;
    localparam logic [16:0] ANGLE_OFFSET = 17'd1800;
    localparam logic [16:0] RCS_OFFSET   = 17'd500;
    localparam int          STORE_DEPTH  = 10;

    localparam logic        STATUS_OK    = 1'b0;
    localparam logic        STATUS_CSUM  = 1'b1;

    typedef struct packed {
        logic signed [16:0] cross_section_tenths;
        logic        [15:0] speed_tenths;
        logic signed [16:0] angle_tenths;
        logic        [15:0] range_tenths;
        logic        [15:0] target_number;
    } t_frame;

endpackage

>>> src/sync_frame_parser_xor_check.sv
// ---------------------------------------------------------------------------
// Sync frame parser with XOR check
// Hunts for the AA 55 header in a byte stream, collects the payload with a
// running XOR and emits one decoded record or a checksum error per frame.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream carries one received byte per transaction in tdata[7:0].
//   Output stream carries one transaction per completed frame, issued for
//   the check byte: tuser is the status (0 good, 1 checksum mismatch) and
//   tdata holds the five record fields; on a mismatch tdata is all zeros.
//   The parser state updates at the accepting edge, so a byte can be taken
//   every cycle while the output is not stalled. The result sits in the
//   output register from the cycle after the check byte is accepted.
//   The output register frees when the result is taken, so the input stays
//   ready while a result waits and is taken in the same cycle; if the
//   receiver stalls with a result pending, tready drops until it drains.
//   Reset (synchronous, active low) returns the parser to header hunting
//   and empties the output register. Payload bytes past the tenth go into
//   the XOR only.
// ---------------------------------------------------------------------------
module sync_frame_parser_xor_check
    import sfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,   // [15:0] target_number, [31:16] range_tenths,
                                          // [48:32] angle_tenths, [64:49] speed_tenths,
                                          // [81:65] cross_section_tenths, [87:82] zero
    output logic [0:0]  o_m_axis_tuser    // [0] frame_status
);

`include "sync_frame_parser_xor_check_assert.svh"

    localparam int CNT_W = $clog2(PAYLOAD_BYTES);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_HDR2  = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    logic [1:0]       r_phase,  n_phase;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [7:0]       r_xor,    n_xor;
    logic [7:0]       r_store [STORE_DEPTH];

    logic             r_m_valid, n_m_valid;
    logic             r_m_status, n_m_status;
    t_frame           r_m_frame,  n_m_frame;

    logic             s_accept;
    logic             m_accept;
    logic             emit;
    logic [15:0]      w_angle_raw;
    logic [15:0]      w_rcs_raw;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_accept        = r_m_valid && i_m_axis_tready;
    assign emit            = s_accept && (r_phase == PH_CHECK);

    assign w_angle_raw = {r_store[4], r_store[5]};
    assign w_rcs_raw   = {r_store[8], r_store[9]};

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_xor   = r_xor;
        if (s_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_s_axis_tdata == HDR_FIRST) n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    if (i_s_axis_tdata == HDR_SECOND) begin
                        n_phase = PH_DATA;
                        n_count = '0;
                        n_xor   = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    n_xor   = r_xor ^ i_s_axis_tdata;
                    n_count = r_count + 1'b1;
                    if (r_count == CNT_W'(PAYLOAD_BYTES - 1)) n_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    n_phase = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        n_m_valid  = r_m_valid && !m_accept;
        n_m_status = r_m_status;
        n_m_frame  = r_m_frame;
        if (emit) begin
            n_m_valid = 1'b1;
            if (i_s_axis_tdata == r_xor) begin
                n_m_status                     = STATUS_OK;
                n_m_frame.target_number        = {r_store[0], r_store[1]};
                n_m_frame.range_tenths         = {r_store[2], r_store[3]};
                n_m_frame.angle_tenths         = signed'({1'b0, w_angle_raw} - ANGLE_OFFSET);
                n_m_frame.speed_tenths         = {r_store[6], r_store[7]};
                n_m_frame.cross_section_tenths = signed'({1'b0, w_rcs_raw} - RCS_OFFSET);
            end else begin
                n_m_status = STATUS_CSUM;
                n_m_frame  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_xor     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_xor     <= n_xor;
            r_m_valid <= n_m_valid;
        end
    end

    // first ten payload bytes, written in arrival order
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (s_accept && (r_phase == PH_DATA) && (r_count == CNT_W'(i))) begin
                r_store[i] <= i_s_axis_tdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_status <= n_m_status;
        r_m_frame  <= n_m_frame;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_status;
    assign o_m_axis_tdata  = {6'b0,
                              r_m_frame.cross_section_tenths,
                              r_m_frame.speed_tenths,
                              r_m_frame.angle_tenths,
                              r_m_frame.range_tenths,
                              r_m_frame.target_number};

    `SFP_ASSERT_ALWAYS(a_reset_empties_output,
        !$past(i_rst_n) |-> !o_m_axis_tvalid,
        "output valid right after reset")
    `SFP_ASSERT(a_result_from_check_byte,
        $rose(o_m_axis_tvalid) |-> $past(emit),
        "result appeared without a check byte")
    `SFP_ASSERT(a_error_has_no_data,
        (o_m_axis_tvalid && (o_m_axis_tuser == STATUS_CSUM)) |-> (o_m_axis_tdata == '0),
        "checksum error result carries data")
    `SFP_ASSERT(a_data_after_sync,
        (r_phase == PH_DATA && $past(r_phase) == PH_HDR2)
            |-> ($past(s_accept) && $past(i_s_axis_tdata) == HDR_SECOND && r_xor == '0),
        "payload phase entered without a full header")

endmodule
